>>> hw/rtl/svb_pkg.sv
// Shared types, constants and helpers for the skinned vertex bounds block.
// Used by svb_mac and skinned_vertex_bounds; depends on nothing else.
package svb_pkg;

  localparam int JOINT_COUNT = 256;
  localparam int FRAC_BITS   = 16;
  localparam int ELEMS       = 12;
  localparam int STORE_DEPTH = JOINT_COUNT * ELEMS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int OPND_W      = 33;
  localparam int PROD_W      = 2 * OPND_W;
  localparam int ACC_W       = PROD_W + 2;

  localparam logic signed [OPND_W-1:0] ONE_Q = OPND_W'(1) <<< FRAC_BITS;
  localparam logic signed [ACC_W-1:0]  HALF_Q = ACC_W'(1) <<< (FRAC_BITS - 1);

  localparam logic [2:0] OP_LOAD_LOCAL  = 3'd0;
  localparam logic [2:0] OP_LOAD_OFFSET = 3'd1;
  localparam logic [2:0] OP_COMPOSE     = 3'd2;
  localparam logic [2:0] OP_SKIN        = 3'd3;
  localparam logic [2:0] OP_CLEAR       = 3'd4;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_MAT1  = 7'b0000010,
    ST_MAT2  = 7'b0000100,
    ST_BLEND = 7'b0001000,
    ST_XFORM = 7'b0010000,
    ST_BOX   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  // One product term on its way through the multiply-accumulate unit.
  typedef struct packed {
    logic       valid;
    logic       first;
    logic       last;
    logic [3:0] dest;
  } term_t;

  // Weight byte scaled by 2^16/255 with rounding; 65536 = 255*257 + 1 makes it exact.
  function automatic logic [16:0] weight_q(logic [7:0] w);
    return {1'b0, w, 8'b0} + {9'b0, w} + {16'b0, w[7]};
  endfunction

  function automatic logic [ADDR_W-1:0] jaddr(logic [7:0] j, logic [3:0] e);
    return ADDR_W'({j, 3'b000}) + ADDR_W'({j, 2'b00}) + ADDR_W'(e);
  endfunction

endpackage

>>> hw/rtl/skinned_vertex_bounds.sv
// Skinned vertex bounds: skins vertices with four-joint blending and grows a box.
// Top level; depends on svb_pkg and svb_mac.
//
// Each input item carries an opcode. Loads write one element of a joint's local
// or offset matrix, compose builds a joint's absolute and skin matrices, skin
// transforms one vertex and grows the box, clear empties the box.
// Every item produces exactly one result item with the box after that item.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// The block takes one item at a time and stalls its input until that item's
// result is in the output register.
// Loads, clear and unused opcodes go straight to the output register. Compose runs two
// passes of 48 products through the single multiply-accumulate unit, each
// followed by a drain of the unit. Skin runs 48 blend products, then 12
// transform products, with drains, and then the box update. The block returns
// to idle as it registers the result, so the next item can be taken while the
// result waits in the output register.
// The shared multiplier issues one product per cycle during each pass.
// A stalled output holds its item; the next item finishes into the output
// register only once the old one has been taken.
// Reset empties the box and clears control state; matrix stores are not
// cleared and hold undefined data until written.
module skinned_vertex_bounds (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         opcode,
  input  logic [7:0]         joint,
  input  logic [3:0]         element,
  input  logic signed [31:0] matrix_value,
  input  logic signed [8:0]  parent,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [31:0]        joint_indices,
  input  logic [31:0]        joint_weights,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] min_x,
  output logic signed [31:0] min_y,
  output logic signed [31:0] min_z,
  output logic signed [31:0] max_x,
  output logic signed [31:0] max_y,
  output logic signed [31:0] max_z,
  output logic               bounds_empty
);
  import svb_pkg::*;

  state_t state;
  logic [5:0] cnt;
  logic [5:0] limit;
  logic       issue_en;
  logic       in_accept;
  logic       mac_busy;
  logic       busy;

  logic [7:0]         cur_joint;
  logic [7:0]         par_idx;
  logic               par_ok;
  logic signed [31:0] px, py, pz;
  logic [31:0]        idx_bytes;
  logic [31:0]        wt_bytes;

  logic [31:0] loc_mem  [STORE_DEPTH];
  logic [31:0] off_mem  [STORE_DEPTH];
  logic [31:0] abs_mem  [STORE_DEPTH];
  logic [31:0] skin_mem [STORE_DEPTH];
  logic [31:0] loc_rd, off_rd, abs_rd, skin_rd;

  logic signed [31:0] abs_buf [ELEMS];
  logic signed [31:0] blend   [ELEMS];
  logic signed [31:0] pt      [3];
  logic signed [31:0] box_min [3];
  logic signed [31:0] box_max [3];
  logic               box_empty;

  logic [3:0] o;
  logic [1:0] k, r, c;
  logic [ADDR_W-1:0] abs_raddr, mat_raddr, skin_raddr, load_addr;
  logic [7:0]  wbyte, ibyte;

  term_t                    s1;
  logic                     s1_amem, s1_bmem;
  logic signed [OPND_W-1:0] s1_a, s1_b;
  logic                     iss_amem, iss_bmem;
  logic signed [OPND_W-1:0] iss_a, iss_b;
  logic signed [OPND_W-1:0] op_a, op_b;
  term_t                    iss_term;

  logic               res_valid;
  logic [3:0]         res_dest;
  logic signed [31:0] res;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign busy      = s1.valid || mac_busy;

  assign limit    = (state == ST_XFORM) ? 6'd12 : 6'd48;
  assign issue_en = (state == ST_MAT1 || state == ST_MAT2 || state == ST_BLEND ||
                     state == ST_XFORM) && (cnt < limit);

  assign o = cnt[5:2];
  assign k = cnt[1:0];
  assign r = o[3:2];
  assign c = o[1:0];

  assign wbyte = wt_bytes[{k, 3'b000} +: 8];
  assign ibyte = idx_bytes[{k, 3'b000} +: 8];

  assign abs_raddr  = jaddr(par_idx, {r, k});
  // The implied bottom row never reads memory; keep the address in range.
  assign mat_raddr  = jaddr(cur_joint, (k == 2'd3) ? 4'd0 : {k, c});
  assign skin_raddr = jaddr(ibyte, o);
  assign load_addr  = jaddr(joint, element);

  // Operands are chosen at issue; memory operands are picked up in the next cycle.
  always_comb begin
    iss_amem = 1'b0;
    iss_bmem = 1'b0;
    iss_a    = '0;
    iss_b    = '0;
    case (state)
      ST_MAT1: begin
        iss_amem = par_ok;
        iss_a    = (r == k) ? ONE_Q : '0;
        iss_bmem = (k != 2'd3);
        iss_b    = (c == 2'd3) ? ONE_Q : '0;
      end
      ST_MAT2: begin
        iss_a    = OPND_W'(abs_buf[{r, k}]);
        iss_bmem = (k != 2'd3);
        iss_b    = (c == 2'd3) ? ONE_Q : '0;
      end
      ST_BLEND: begin
        iss_amem = 1'b1;
        iss_b    = OPND_W'(weight_q(wbyte));
      end
      ST_XFORM: begin
        iss_a = OPND_W'(blend[{c, k}]);
        case (k)
          2'd0:    iss_b = OPND_W'(px);
          2'd1:    iss_b = OPND_W'(py);
          2'd2:    iss_b = OPND_W'(pz);
          default: iss_b = ONE_Q;
        endcase
      end
      default: begin
        iss_a = '0;
      end
    endcase
    iss_term.valid = issue_en;
    iss_term.first = (k == 2'd0);
    iss_term.last  = (k == 2'd3);
    iss_term.dest  = o;
  end

  assign op_a = s1_amem ? OPND_W'($signed(state == ST_MAT1 ? abs_rd : skin_rd)) : s1_a;
  assign op_b = s1_bmem ? OPND_W'($signed(state == ST_MAT1 ? loc_rd : off_rd)) : s1_b;

  svb_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .term_in   (s1),
    .op_a      (op_a),
    .op_b      (op_b),
    .busy      (mac_busy),
    .res_valid (res_valid),
    .res_dest  (res_dest),
    .res       (res)
  );

  // Matrix stores.
  always_ff @(posedge clk) begin
    if (in_accept && opcode == OP_LOAD_LOCAL && element < 4'(ELEMS)) begin
      loc_mem[load_addr] <= matrix_value;
    end
    loc_rd <= loc_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && opcode == OP_LOAD_OFFSET && element < 4'(ELEMS)) begin
      off_mem[load_addr] <= matrix_value;
    end
    off_rd <= off_mem[mat_raddr];
  end

  // The absolute matrix is committed only after the parent has been read,
  // so a joint that is its own parent sees its previous matrix.
  always_ff @(posedge clk) begin
    if (state == ST_MAT2 && issue_en && cnt < 6'(ELEMS)) begin
      abs_mem[jaddr(cur_joint, cnt[3:0])] <= abs_buf[cnt[3:0]];
    end
    abs_rd <= abs_mem[abs_raddr];
  end

  always_ff @(posedge clk) begin
    if (res_valid && state == ST_MAT2) begin
      skin_mem[jaddr(cur_joint, res_dest)] <= res;
    end
    skin_rd <= skin_mem[skin_raddr];
  end

  // Result buffers.
  always_ff @(posedge clk) begin
    if (res_valid) begin
      case (state)
        ST_MAT1:  abs_buf[res_dest] <= res;
        ST_BLEND: blend[res_dest]   <= res;
        ST_XFORM: pt[res_dest[1:0]] <= res;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_amem <= iss_amem;
    s1_bmem <= iss_bmem;
    s1_a    <= iss_a;
    s1_b    <= iss_b;
    if (in_accept) begin
      cur_joint <= joint;
      par_idx   <= parent[7:0];
      par_ok    <= !parent[8];
      px        <= pos_x;
      py        <= pos_y;
      pz        <= pos_z;
      idx_bytes <= joint_indices;
      wt_bytes  <= joint_weights;
    end
    if (rst) begin
      s1 <= '0;
    end else begin
      s1 <= iss_term;
    end
  end

  // Sequencer and box.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      box_empty <= 1'b1;
      out_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        box_min[i] <= '0;
        box_max[i] <= '0;
      end
    end else begin
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      if (issue_en) begin
        cnt <= cnt + 6'd1;
      end
      case (state)
        ST_IDLE: begin
          cnt <= '0;
          if (in_accept) begin
            case (opcode)
              OP_COMPOSE: state <= ST_MAT1;
              OP_SKIN:    state <= ST_BLEND;
              OP_CLEAR: begin
                box_empty <= 1'b1;
                for (int i = 0; i < 3; i++) begin
                  box_min[i] <= '0;
                  box_max[i] <= '0;
                end
                state <= ST_OUT;
              end
              default: state <= ST_OUT;
            endcase
          end
        end
        ST_MAT1, ST_MAT2, ST_BLEND, ST_XFORM: begin
          if (cnt == limit && !busy) begin
            cnt <= '0;
            case (state)
              ST_MAT1:  state <= ST_MAT2;
              ST_BLEND: state <= ST_XFORM;
              ST_XFORM: state <= ST_BOX;
              default:  state <= ST_OUT;
            endcase
          end
        end
        ST_BOX: begin
          for (int i = 0; i < 3; i++) begin
            if (box_empty || pt[i] < box_min[i]) begin
              box_min[i] <= pt[i];
            end
            if (box_empty || pt[i] > box_max[i]) begin
              box_max[i] <= pt[i];
            end
          end
          box_empty <= 1'b0;
          state     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid    <= 1'b1;
            min_x        <= box_empty ? '0 : box_min[0];
            min_y        <= box_empty ? '0 : box_min[1];
            min_z        <= box_empty ? '0 : box_min[2];
            max_x        <= box_empty ? '0 : box_max[0];
            max_y        <= box_empty ? '0 : box_max[1];
            max_z        <= box_empty ? '0 : box_max[2];
            bounds_empty <= box_empty;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/svb_mac.sv
// Shared multiply-accumulate unit: one product per cycle, round half up, saturate.
// Depends on svb_pkg.
module svb_mac (
  input  logic                                  clk,
  input  logic                                  rst,
  input  svb_pkg::term_t                        term_in,
  input  logic signed [svb_pkg::OPND_W-1:0]     op_a,
  input  logic signed [svb_pkg::OPND_W-1:0]     op_b,
  output logic                                  busy,
  output logic                                  res_valid,
  output logic [3:0]                            res_dest,
  output logic signed [31:0]                    res
);
  import svb_pkg::*;

  term_t                    t2;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic [ACC_W-FRAC_BITS-32:0] acc_hi;
  logic signed [31:0]       res_next;

  always_comb begin
    acc_next = (t2.first ? HALF_Q : acc) + ACC_W'(prod);
    acc_hi   = acc_next[ACC_W-1:FRAC_BITS+31];
    if (&acc_hi || ~|acc_hi) begin
      res_next = acc_next[FRAC_BITS+31:FRAC_BITS];
    end else if (acc_next[ACC_W-1]) begin
      res_next = 32'sh8000_0000;
    end else begin
      res_next = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (t2.valid) begin
      acc <= acc_next;
    end
    if (t2.valid && t2.last) begin
      res      <= res_next;
      res_dest <= t2.dest;
    end
    if (rst) begin
      t2        <= '0;
      res_valid <= 1'b0;
    end else begin
      t2        <= term_in;
      res_valid <= t2.valid && t2.last;
    end
  end

  assign busy = t2.valid || res_valid;

endmodule
